// File: sv/bsa_pkg.sv
// package: shared types and constants of the breakpoint slot allocator
package bsa_pkg;

    // payload field widths
    localparam int ACTION_W     = 1;
    localparam int REQ_CLASS_W  = 8;
    localparam int ADDR_PORT_W  = 64;
    localparam int STATUS_W     = 2;
    localparam int SLOT_IDX_W   = 4;
    localparam int SLOT_COUNT_W = 5;

    // apb configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from the word address bit of paddr
    localparam logic REG_SLOT_COUNT = 1'b0;

    // slot count after reset
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 5'd16;

    // request actions
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // highest supported breakpoint class
    localparam logic [REQ_CLASS_W-1:0] CLASS_MAX = 8'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_CLASS = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic reject;
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: sv/bsa_req_if.sv
// interface: request channel carrying one breakpoint add or remove item
interface bsa_req_if;
    import bsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [REQ_CLASS_W-1:0] request_class;
    logic [ADDR_PORT_W-1:0] address;

    modport source (
        output valid,
        output action,
        output request_class,
        output address,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  request_class,
        input  address,
        output ready
    );
endinterface

// File: sv/bsa_rsp_if.sv
// interface: result channel carrying one comparator update item
interface bsa_rsp_if;
    import bsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic                   comparator_write;
    logic [SLOT_IDX_W-1:0]  slot_index;
    logic [ADDR_PORT_W-1:0] comparator_address;
    logic                   comparator_enable;

    modport source (
        output valid,
        output status,
        output comparator_write,
        output slot_index,
        output comparator_address,
        output comparator_enable,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  comparator_write,
        input  slot_index,
        input  comparator_address,
        input  comparator_enable,
        output ready
    );
endinterface

// File: sv/breakpoint_slot_allocator_core.sv
// Breakpoint slot allocator: manages hardware breakpoint comparator slots.
// Request channel i_req carries action (add or remove), request_class and
// address; result channel o_rsp returns one item per request with status,
// comparator_write, slot_index, comparator_address and comparator_enable.
// Both channels move an item when valid and ready are high at a clock edge.
// The slot count register sits at APB byte address 0; the user must write it
// only while the block is idle, which the block itself does not enforce;
// pready is always high. Each request walks the usable slots one per cycle
// through a single read port of the slot address memory; a match on a slot
// ends the walk early. Requests of an unsupported class and any request with
// no usable slot end the walk at once. One request is in flight at a time;
// i_req.ready is high only when the sequencer is idle.
// The result sits in an output register: the next request is accepted and
// searched while it waits, and only its completion waits for o_rsp.ready.
// Synchronous active-low reset clears all slot valid bits and sets the slot
// count to 16; i_req.ready is low during reset and no result is pending.
module breakpoint_slot_allocator_core #(
    parameter int MAX_SLOTS  = 16,
    parameter int ADDR_WIDTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bsa_req_if.sink                          i_req,
    bsa_rsp_if.source                        o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bsa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bsa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bsa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import bsa_pkg::*;

    logic [SLOT_COUNT_W-1:0] r_slot_count;
    logic                    cfg_wr;
    t_dp_cmd                 cmd;
    t_dp_status              dp_status;

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_COUNT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_SLOT_COUNT)) begin
            r_slot_count <= pwdata[SLOT_COUNT_W-1:0];
        end
    end

    // register readback
    always_comb begin
        if (paddr[2] == REG_SLOT_COUNT) begin
            prdata = APB_DATA_W'(r_slot_count);
        end else begin
            prdata = '0;
        end
    end

    // sequencer
    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // slot table and search
    bsa_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (dp_status),
        .i_slot_count  (r_slot_count),
        .i_req_action  (i_req.action),
        .i_req_class   (i_req.request_class),
        .i_req_address (i_req.address),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_out_status  (o_rsp.status),
        .o_out_write   (o_rsp.comparator_write),
        .o_out_slot    (o_rsp.slot_index),
        .o_out_address (o_rsp.comparator_address),
        .o_out_enable  (o_rsp.comparator_enable)
    );

endmodule

// File: sv/bsa_ctrl.sv
// module: sequencing state machine of the breakpoint slot allocator
module bsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bsa_pkg::t_dp_status i_status,
    output bsa_pkg::t_dp_cmd    o_cmd
);
    import bsa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // commands, no request taken while in reset
    always_comb begin
        o_in_ready   = i_rst_n && (r_state == ST_IDLE);
        o_cmd.start  = o_in_ready && i_in_valid;
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.finish = (r_state == ST_FINISH) && i_status.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.reject || i_status.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/bsa_dp.sv
// module: slot table, sequential search and result register of the allocator
module bsa_dp #(
    parameter int MAX_SLOTS  = 16,
    parameter int ADDR_WIDTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bsa_pkg::t_dp_cmd                     i_cmd,
    output bsa_pkg::t_dp_status                  o_status,
    input  logic [bsa_pkg::SLOT_COUNT_W-1:0]     i_slot_count,
    input  logic [bsa_pkg::ACTION_W-1:0]         i_req_action,
    input  logic [bsa_pkg::REQ_CLASS_W-1:0]      i_req_class,
    input  logic [bsa_pkg::ADDR_PORT_W-1:0]      i_req_address,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [bsa_pkg::STATUS_W-1:0]         o_out_status,
    output logic                                 o_out_write,
    output logic [bsa_pkg::SLOT_IDX_W-1:0]       o_out_slot,
    output logic [bsa_pkg::ADDR_PORT_W-1:0]      o_out_address,
    output logic                                 o_out_enable
);
    import bsa_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    // captured request
    logic [ACTION_W-1:0]    r_action;
    logic [REQ_CLASS_W-1:0] r_class;
    logic [ADDR_WIDTH-1:0]  r_addr;
    logic [CNT_W-1:0]       r_n;

    // search state
    logic [CNT_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_chk_on;
    logic [ADDR_WIDTH-1:0] r_rd_q;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;

    // slot table
    logic [MAX_SLOTS-1:0]  r_valid;
    logic [ADDR_WIDTH-1:0] r_slot_mem [MAX_SLOTS];

    // result register
    logic                   r_out_vld;
    logic [STATUS_W-1:0]    r_out_status;
    logic                   r_out_write;
    logic [SLOT_IDX_W-1:0]  r_out_slot;
    logic [ADDR_PORT_W-1:0] r_out_address;
    logic                   r_out_enable;

    logic [CNT_W-1:0]   usable_cnt;
    logic               rd_go;
    logic [IDX_W-1:0]   rd_idx;
    logic               chk_valid;
    logic               chk_match;
    logic               chk_free;
    logic               reject;
    logic               set_slot;
    logic               clr_slot;
    logic [STATUS_W-1:0] res_status;

    // slot count saturates at the table depth
    always_comb begin
        if (int'(i_slot_count) > MAX_SLOTS) begin
            usable_cnt = CNT_W'(MAX_SLOTS);
        end else begin
            usable_cnt = CNT_W'(i_slot_count);
        end
    end

    // one table read per cycle, compared in the following cycle
    assign rd_go     = i_cmd.scan && (r_rd_idx < r_n);
    assign rd_idx    = r_rd_idx[IDX_W-1:0];
    assign chk_valid = r_valid[r_chk_idx];
    assign chk_match = r_chk_on && chk_valid && (r_rd_q == r_addr);
    assign chk_free  = r_chk_on && !chk_valid;
    assign reject    = (r_class > CLASS_MAX);

    // status to controller
    always_comb begin
        o_status.reject    = reject;
        o_status.scan_done = r_hit || (!r_chk_on && (r_rd_idx >= r_n));
        o_status.out_free  = !r_out_vld || i_out_ready;
    end

    // result decision
    always_comb begin
        set_slot   = 1'b0;
        clr_slot   = 1'b0;
        res_status = STAT_MISS;
        if (reject) begin
            res_status = STAT_BAD_CLASS;
        end else if (r_action == ACT_ADD) begin
            if (r_hit) begin
                res_status = STAT_OK;
            end else if (r_free_found) begin
                res_status = STAT_OK;
                set_slot   = i_cmd.finish;
            end
        end else begin
            if (r_hit) begin
                res_status = STAT_OK;
                clr_slot   = i_cmd.finish;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_chk_on     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_chk_on     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_on <= rd_go;
                if (chk_match) begin
                    r_hit <= 1'b1;
                end
                if (chk_free) begin
                    r_free_found <= 1'b1;
                end
            end else if (i_cmd.finish) begin
                r_chk_on     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                if (set_slot) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (clr_slot) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request capture, search indexes and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_action <= i_req_action;
            r_class  <= i_req_class;
            r_addr   <= i_req_address[ADDR_WIDTH-1:0];
            r_n      <= usable_cnt;
            r_rd_idx <= '0;
        end else if (i_cmd.scan) begin
            if (rd_go) begin
                r_rd_idx  <= r_rd_idx + CNT_W'(1);
                r_chk_idx <= rd_idx;
            end
            if (chk_match && !r_hit) begin
                r_hit_idx <= r_chk_idx;
            end
            if (chk_free && !r_free_found) begin
                r_free_idx <= r_chk_idx;
            end
        end
        if (i_cmd.finish) begin
            r_out_status  <= res_status;
            r_out_write   <= set_slot || clr_slot;
            r_out_enable  <= set_slot;
            r_out_address <= set_slot ? ADDR_PORT_W'(r_addr) : '0;
            if (set_slot) begin
                r_out_slot <= SLOT_IDX_W'(r_free_idx);
            end else if (clr_slot) begin
                r_out_slot <= SLOT_IDX_W'(r_hit_idx);
            end else begin
                r_out_slot <= '0;
            end
        end
    end

    // slot address memory
    always_ff @(posedge i_clk) begin
        if (set_slot) begin
            r_slot_mem[r_free_idx] <= r_addr;
        end
        if (rd_go) begin
            r_rd_q <= r_slot_mem[rd_idx];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_status  = r_out_status;
    assign o_out_write   = r_out_write;
    assign o_out_slot    = r_out_slot;
    assign o_out_address = r_out_address;
    assign o_out_enable  = r_out_enable;

`ifndef SYNTH
    // a matched slot stays valid until the request finishes
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_valid[r_hit_idx])
        else $error("hit slot not valid");

    // a recorded free slot stays free until the request finishes
    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_found |-> !r_valid[r_free_idx])
        else $error("free slot already valid");

    // only slots below the usable count are compared
    a_chk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_on |-> (CNT_W'(r_chk_idx) < r_n))
        else $error("compare outside usable slots");

    // a result is loaded only into a free result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten");
`endif

endmodule

// File: sim/testbench.sv
// testbench for the breakpoint slot allocator: directed table, then random phases
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int MAX_SLOTS      = 16;
    localparam int ADDR_WIDTH     = 64;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [ADDR_PORT_W-1:0] ADDR_MASK =
        {ADDR_PORT_W{1'b1}} >> (ADDR_PORT_W - ADDR_WIDTH);
    localparam logic [ADDR_PORT_W-1:0] ALL_ONES = {ADDR_PORT_W{1'b1}};

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] SLOT_COUNT_ADDR = 3'd0;
    localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [REQ_CLASS_W-1:0] request_class;
        logic [ADDR_PORT_W-1:0] address;
    } t_bp_request;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   comparator_write;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic [ADDR_PORT_W-1:0] comparator_address;
        logic                   comparator_enable;
    } t_bp_update;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_bp_request            req;
        logic                   typed;
        t_bp_update             upd;
        logic [APB_ADDR_W-1:0]  reg_addr;
        logic [APB_DATA_W-1:0]  reg_data;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bsa_req_if req_if();
    bsa_rsp_if rsp_if();

    breakpoint_slot_allocator_core #(
        .MAX_SLOTS  (MAX_SLOTS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the slot table and the slot count register
    logic                   bp_armed [MAX_SLOTS];
    logic [ADDR_PORT_W-1:0] bp_addr  [MAX_SLOTS];
    logic [SLOT_COUNT_W-1:0] cfg_slots;

    t_bp_update             expected_updates [$];
    t_plan_row              plan [$];
    logic [ADDR_PORT_W-1:0] addr_pool [$];
    int                     err_count;
    int                     quiet_cycles;
    logic [31:0]            stall_cycle;
    int                     stall_left;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // expected comparator update for one request, advancing the shadow table
    function automatic t_bp_update compute_breakpoint_update(t_bp_request r);
        t_bp_update             res;
        logic [ADDR_PORT_W-1:0] a;
        int                     n;
        int                     hit;
        int                     free_slot;
        res = '0;
        a = r.address & ADDR_MASK;
        n = (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots);
        if (r.request_class > CLASS_MAX) begin
            res.status = STAT_BAD_CLASS;
            return res;
        end
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && bp_armed[i] && bp_addr[i] == a) hit = i;
            if (free_slot < 0 && !bp_armed[i]) free_slot = i;
        end
        if (r.action == ACT_ADD) begin
            // already present: nothing rewritten
            if (hit >= 0) begin
                res.status = STAT_OK;
            end else if (free_slot < 0) begin
                res.status = STAT_MISS;
            end else begin
                bp_armed[free_slot] = 1'b1;
                bp_addr[free_slot] = a;
                res.status = STAT_OK;
                res.comparator_write = 1'b1;
                res.slot_index = SLOT_IDX_W'(free_slot);
                res.comparator_address = a;
                res.comparator_enable = 1'b1;
            end
        end else if (hit >= 0) begin
            bp_armed[hit] = 1'b0;
            res.status = STAT_OK;
            res.comparator_write = 1'b1;
            res.slot_index = SLOT_IDX_W'(hit);
        end else begin
            res.status = STAT_MISS;
        end
        return res;
    endfunction

    function automatic t_bp_update mk_update(logic [STATUS_W-1:0] status, logic wr,
                                             logic [SLOT_IDX_W-1:0] idx,
                                             logic [ADDR_PORT_W-1:0] caddr, logic en);
        t_bp_update u;
        u.status = status;
        u.comparator_write = wr;
        u.slot_index = idx;
        u.comparator_address = caddr;
        u.comparator_enable = en;
        return u;
    endfunction

    function automatic t_plan_row request_row(logic [ACTION_W-1:0] action,
                                              logic [REQ_CLASS_W-1:0] cls,
                                              logic [ADDR_PORT_W-1:0] addr);
        t_plan_row row;
        row = '0;
        row.kind = ROW_REQUEST;
        row.req.action = action;
        row.req.request_class = cls;
        row.req.address = addr;
        return row;
    endfunction

    function automatic t_plan_row checked_row(logic [ACTION_W-1:0] action,
                                              logic [REQ_CLASS_W-1:0] cls,
                                              logic [ADDR_PORT_W-1:0] addr,
                                              t_bp_update upd);
        t_plan_row row;
        row = request_row(action, cls, addr);
        row.typed = 1'b1;
        row.upd = upd;
        return row;
    endfunction

    function automatic t_plan_row config_row(logic [APB_ADDR_W-1:0] addr,
                                             logic [APB_DATA_W-1:0] data);
        t_plan_row row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.reg_addr = addr;
        row.reg_data = data;
        return row;
    endfunction

    task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (act !== exp) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
        end
    endtask

    // drive one request item and record its expected update on acceptance
    task automatic issue_request(t_bp_request r, logic use_typed, t_bp_update typed_upd);
        t_bp_update pred;
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.action        <= r.action;
        req_if.request_class <= r.request_class;
        req_if.address       <= r.address;
        do @(posedge i_clk); while (!req_if.ready);
        pred = compute_breakpoint_update(r);
        expected_updates.push_back(use_typed ? typed_upd : pred);
    endtask

    // stop sending and wait for every outstanding update
    task automatic quiesce();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[APB_ADDR_W-1:2] == REG_SLOT_COUNT) cfg_slots = data[SLOT_COUNT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_slot_count();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SLOT_COUNT_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("slot_count readback", {{(64-SLOT_COUNT_W){1'b0}}, cfg_slots}, 64'(prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin : update_check
        t_bp_update exp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_updates.size() == 0) begin
                err_count++;
                $display("%0t: result item with no request waiting, expected none, actual %h",
                         $time, {rsp_if.status, rsp_if.comparator_write, rsp_if.slot_index,
                                 rsp_if.comparator_address, rsp_if.comparator_enable});
            end else begin
                exp = expected_updates.pop_front();
                check_field("status", 64'(exp.status), 64'(rsp_if.status));
                check_field("comparator_write", 64'(exp.comparator_write),
                            64'(rsp_if.comparator_write));
                check_field("slot_index", 64'(exp.slot_index), 64'(rsp_if.slot_index));
                check_field("comparator_address", exp.comparator_address,
                            rsp_if.comparator_address);
                check_field("comparator_enable", 64'(exp.comparator_enable),
                            64'(rsp_if.comparator_enable));
            end
        end
    end

    // receiver stalls: quiet stretches without stalls, otherwise random stalls
    always @(negedge i_clk) begin : rsp_stall
        logic nxt;
        nxt = 1'b1;
        stall_cycle = stall_cycle + 1;
        if (stall_cycle[9:8] != 2'd0) begin
            if (stall_left != 0) begin
                nxt = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 8);
            end
        end
        rsp_if.ready <= nxt;
    end

    // count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (req_if.valid && req_if.ready) ||
            (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int                      phase_len;
        int                      gap;
        int                      burst_left;
        int                      sent;
        int                      pick;
        logic [APB_DATA_W-1:0]   cnt_word;
        t_bp_request             r;

        err_count    = 0;
        quiet_cycles = 0;
        stall_cycle  = '0;
        stall_left   = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_if.valid = 1'b0;
        req_if.action = '0;
        req_if.request_class = '0;
        req_if.address = '0;
        rsp_if.ready = 1'b0;
        cfg_slots    = SLOT_COUNT_RESET;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            bp_armed[i] = 1'b0;
            bp_addr[i]  = '0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, starting from the reset slot count of 16
        plan.push_back(checked_row(ACT_ADD, 8'd0, '0, mk_update(STAT_OK, 1, 0, '0, 1)));
        plan.push_back(checked_row(ACT_ADD, 8'd1, ALL_ONES,
                                   mk_update(STAT_OK, 1, 1, ALL_ONES, 1)));
        // address already held
        plan.push_back(checked_row(ACT_ADD, 8'd0, '0, mk_update(STAT_OK, 0, 0, '0, 0)));
        // unsupported class, both actions
        plan.push_back(checked_row(ACT_ADD, 8'd2, 64'd5, mk_update(STAT_BAD_CLASS, 0, 0, '0, 0)));
        plan.push_back(checked_row(ACT_REMOVE, 8'd255, '0,
                                   mk_update(STAT_BAD_CLASS, 0, 0, '0, 0)));
        // remove of an address not held
        plan.push_back(checked_row(ACT_REMOVE, 8'd1, 64'h1234, mk_update(STAT_MISS, 0, 0, '0, 0)));
        plan.push_back(checked_row(ACT_REMOVE, 8'd0, '0, mk_update(STAT_OK, 1, 0, '0, 0)));
        plan.push_back(checked_row(ACT_ADD, 8'd1, 64'hA5A5_A5A5_A5A5_A5A5,
                                   mk_update(STAT_OK, 1, 0, 64'hA5A5_A5A5_A5A5_A5A5, 1)));
        // table full with two usable slots
        plan.push_back(config_row(SLOT_COUNT_ADDR, 32'd2));
        plan.push_back(checked_row(ACT_ADD, 8'd0, 64'h5A5A_5A5A_5A5A_5A5A,
                                   mk_update(STAT_MISS, 0, 0, '0, 0)));
        // slot 1 now above the count and hidden
        plan.push_back(config_row(SLOT_COUNT_ADDR, 32'd1));
        plan.push_back(checked_row(ACT_REMOVE, 8'd1, ALL_ONES, mk_update(STAT_MISS, 0, 0, '0, 0)));
        plan.push_back(checked_row(ACT_ADD, 8'd1, ALL_ONES, mk_update(STAT_MISS, 0, 0, '0, 0)));
        // no usable slot at all
        plan.push_back(config_row(SLOT_COUNT_ADDR, 32'd0));
        plan.push_back(checked_row(ACT_ADD, 8'd0, 64'd7, mk_update(STAT_MISS, 0, 0, '0, 0)));
        plan.push_back(checked_row(ACT_REMOVE, 8'd0, 64'hA5A5_A5A5_A5A5_A5A5,
                                   mk_update(STAT_MISS, 0, 0, '0, 0)));
        // count of 31 saturates to the full table, hidden slot visible again
        plan.push_back(config_row(SLOT_COUNT_ADDR, 32'hFFFF_FFFF));
        plan.push_back(checked_row(ACT_ADD, 8'd1, ALL_ONES, mk_update(STAT_OK, 0, 0, '0, 0)));
        plan.push_back(checked_row(ACT_ADD, 8'd0, 64'h8000_0000_0000_0001,
                                   mk_update(STAT_OK, 1, 2, 64'h8000_0000_0000_0001, 1)));
        plan.push_back(checked_row(ACT_REMOVE, 8'd1, ALL_ONES, mk_update(STAT_OK, 1, 1, '0, 0)));
        // write to a register index that does not exist
        plan.push_back(config_row(UNUSED_REG_ADDR, 32'd0));
        plan.push_back(request_row(ACT_ADD, 8'd1, 64'h0123_4567_89AB_CDEF));
        plan.push_back(request_row(ACT_REMOVE, 8'd0, 64'h8000_0000_0000_0001));
        plan.push_back(config_row(SLOT_COUNT_ADDR, 32'd16));

        check_slot_count();
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CONFIG) begin
                quiesce();
                write_register(plan[k].reg_addr, plan[k].reg_data);
                check_slot_count();
            end else begin
                issue_request(plan[k].req, plan[k].typed, plan[k].upd);
            end
        end
        quiesce();

        // random phases, each with its own slot count and address pool
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: cnt_word = 32'd0;
                1: cnt_word = 32'd1;
                2: cnt_word = 32'd16;
                3: cnt_word = $urandom_range(17, 31);
                default: cnt_word = $urandom_range(2, 15);
            endcase
            cnt_word = ($urandom() & ~32'h1F) | cnt_word;
            write_register(SLOT_COUNT_ADDR, cnt_word);
            if ($urandom_range(0, 3) == 0) write_register(UNUSED_REG_ADDR, $urandom());
            check_slot_count();

            // pool holds the stored addresses so removes can drain the table
            addr_pool.delete();
            for (int i = 0; i < MAX_SLOTS; i++)
                if (bp_armed[i]) addr_pool.push_back(bp_addr[i]);
            repeat ($urandom_range(2, 10))
                addr_pool.push_back({$urandom(), $urandom()} & ADDR_MASK);
            if ($urandom_range(0, 3) == 0) addr_pool.push_back('0);
            if ($urandom_range(0, 3) == 0) addr_pool.push_back(ALL_ONES);

            phase_len = $urandom_range(40, 140);
            burst_left = 0;
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                // sender bursts with random gaps
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 5);
                    if (gap != 0) begin
                        @(negedge i_clk);
                        req_if.valid <= 1'b0;
                        repeat (gap - 1) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
                r.action = ACTION_W'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0)
                    r.request_class = REQ_CLASS_W'($urandom_range(2, 255));
                else r.request_class = REQ_CLASS_W'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) r.address = {$urandom(), $urandom()};
                else r.address = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                issue_request(r, 1'b0, '0);
                burst_left--;
                sent++;
            end
            quiesce();
        end

        // let any stray result show up
        repeat (MAX_SLOTS + 16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
